FILE: hw/rtl/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// Holds the sequencer states, request and result codes, and default sizes.
// Depends on nothing; every other file refers to it by scoped names.
package srr_pkg;

   // Default link configuration: 3-bit sequence numbers, window of four.
   localparam int SEQ_MAX_DEF = 7;
   localparam int WINDOW_DEF  = 4;

   // Request codes on req_type.
   localparam logic [1:0] REQ_DATA    = 2'd0;
   localparam logic [1:0] REQ_CRC_ERR = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;

   // Result codes on rsp_out_kind.
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DRAIN_RD,
      ST_DRAIN_EM,
      ST_ACK,
      ST_FINISH
   } state_type;

   // Strobes from the sequencer to the slot buffer.
   typedef struct packed {
      logic set;    // store a byte and mark its slot full
      logic clear;  // mark the slot under the read index empty
      logic read;   // fetch the byte under the read index
   } slot_ctl_type;

endpackage

FILE: hw/rtl/srr_slot_buf.sv
// Receive slot buffer: byte storage plus one full flag per slot.
// Uses srr_pkg::slot_ctl_type for its strobes; instantiated by the top level.
module srr_slot_buf #(
   parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srr_pkg::slot_ctl_type      ctl,
   input  logic [$clog2(WINDOW)-1:0]  wr_idx,
   input  logic [7:0]                 wr_byte,
   input  logic [$clog2(WINDOW)-1:0]  rd_idx,
   output logic [7:0]                 rd_byte,
   input  logic [$clog2(WINDOW)-1:0]  chk_idx,
   output logic                       chk_filled
);

   logic [7:0]        mem [WINDOW];
   logic [7:0]        rd_byte_ff;
   logic [WINDOW-1:0] filled_ff;
   logic [WINDOW-1:0] filled_in;

   // Byte storage has no reset; a slot is only read after it was stored.
   always_ff @(posedge clock) begin
      if (ctl.set) begin
         mem[wr_idx] <= wr_byte;
      end
      if (ctl.read) begin
         rd_byte_ff <= mem[rd_idx];
      end
   end

   always_comb begin
      filled_in = filled_ff;
      if (ctl.clear) begin
         filled_in[rd_idx] = 1'b0;
      end
      if (ctl.set) begin
         filled_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else begin
         filled_ff <= filled_in;
      end
   end

   assign rd_byte    = rd_byte_ff;
   assign chk_filled = filled_ff[chk_idx];

endmodule

FILE: hw/rtl/selective_repeat_receiver.sv
// Receiver half of a selective-repeat sliding-window link: top level.
// Depends on srr_pkg and instantiates srr_slot_buf.
//
// Each accepted request beat is a good data frame, a checksum error or an ack
// timeout, and it produces zero to WINDOW+1 response beats, the final one
// flagged by rsp_last. A data frame carrying an unexpected sequence number
// answers with a NAK while NAKs are armed; otherwise a frame that falls inside
// the circular receive window and whose slot is empty is buffered, then all
// buffered bytes that are now in order are delivered, their slots freed and
// the window slid forward, and an ACK carrying the next expected number
// follows unless req_more_waiting says another frame is queued. A checksum
// error sends a NAK if armed, and a timeout resends the ACK. Sending a NAK
// disarms NAKs and delivering a byte re-arms them; request code 3 is ignored.
// Incoming sequence numbers are reduced modulo SEQ_MAX+1. The block takes one
// request at a time under a small sequencer: req_stall is low only while it is
// idle. Each delivered byte is fetched through the single read port of the
// slot memory, whose registered read feeds the shared step unit that emits
// the byte and advances the expected number, the window edge and the slot
// pointer together. Each result is held one step in a staging register so
// that rsp_last is known when it is shown, and an output register lets a
// waiting response beat sit while the sequencer moves on.
// There is no clearing pass after reset.
module selective_repeat_receiver #(
   parameter int SEQ_MAX = srr_pkg::SEQ_MAX_DEF,
   parameter int WINDOW  = srr_pkg::WINDOW_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [2:0] req_frame_seq,
   input  logic [7:0] req_frame_byte,
   input  logic       req_more_waiting,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_ack_number,
   output logic       rsp_last
);

   localparam int SW      = $clog2(SEQ_MAX + 1);
   localparam int IW      = $clog2(WINDOW);
   localparam int CW      = $clog2(WINDOW + 1);
   localparam int WUP_RST = WINDOW % (SEQ_MAX + 1);

   srr_pkg::state_type state_ff, state_in;

   // Window state.
   logic [SW-1:0] exp_ff, exp_in;
   logic [SW-1:0] wup_ff, wup_in;
   logic [IW-1:0] eslot_ff, eslot_in;
   logic          nak_ff, nak_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Request being worked on.
   logic [1:0]    type_ff, type_in;
   logic [SW-1:0] seq_ff, seq_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [7:0]    byte_ff, byte_in;
   logic          more_ff, more_in;

   // Staging register for the most recent result.
   logic          pend_valid_ff, pend_valid_in;
   logic [1:0]    pend_kind_ff, pend_kind_in;
   logic [7:0]    pend_byte_ff, pend_byte_in;
   logic [2:0]    pend_num_ff, pend_num_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic [2:0]    rsp_num_ff, rsp_num_in;
   logic          rsp_last_ff, rsp_last_in;

   srr_pkg::slot_ctl_type slot_ctl;
   logic [IW-1:0]         chk_idx;
   logic                  chk_filled;
   logic [7:0]            rd_byte;

   logic       accept;
   logic       rsp_free;
   logic       can_emit;
   logic       emit;
   logic       finish_move;
   logic [1:0] emit_kind;
   logic [7:0] emit_byte;
   logic [8:0] seq_wide;
   logic [8:0] slot_wide;
   logic [8:0] exp_wide;
   logic [2:0] exp_num;
   logic       in_win;
   logic       exp_wrap;

   assign accept   = req_valid && (state_ff == srr_pkg::ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   // A new result may enter staging if staging is empty or can move out now.
   assign can_emit = !pend_valid_ff || rsp_free;

   // Sequence number reduction and slot index of the arriving frame. The raw
   // number is below eight, so one subtraction brings it under SEQ_MAX+1 and
   // at most three bring it under WINDOW.
   always_comb begin
      seq_wide = 9'(req_frame_seq);
      if (seq_wide > 9'(SEQ_MAX)) begin
         seq_wide = seq_wide - 9'(SEQ_MAX + 1);
      end
      slot_wide = seq_wide;
      for (int k = 0; k < 3; k++) begin
         if (slot_wide >= 9'(WINDOW)) begin
            slot_wide = slot_wide - 9'(WINDOW);
         end
      end
   end

   assign exp_wide = 9'(exp_ff);
   assign exp_num  = exp_wide[2:0];
   assign exp_wrap = (exp_ff == SW'(SEQ_MAX));

   // Circular window test: expected <= seq < upper, modulo the sequence space.
   assign in_win = ((exp_ff <= seq_ff) && (seq_ff < wup_ff)) ||
                   ((wup_ff < exp_ff) && (exp_ff <= seq_ff)) ||
                   ((seq_ff < wup_ff) && (wup_ff < exp_ff));

   assign chk_idx = (state_ff == srr_pkg::ST_DECIDE) ? slot_ff : eslot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srr_pkg::ST_IDLE;
         exp_ff        <= '0;
         wup_ff        <= SW'(WUP_RST);
         eslot_ff      <= '0;
         nak_ff        <= 1'b1;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         exp_ff        <= exp_in;
         wup_ff        <= wup_in;
         eslot_ff      <= eslot_in;
         nak_ff        <= nak_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      seq_ff       <= seq_in;
      slot_ff      <= slot_in;
      byte_ff      <= byte_in;
      more_ff      <= more_in;
      pend_kind_ff <= pend_kind_in;
      pend_byte_ff <= pend_byte_in;
      pend_num_ff  <= pend_num_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Sequencer: next state, window updates and result generation.
   always_comb begin
      state_in    = state_ff;
      exp_in      = exp_ff;
      wup_in      = wup_ff;
      eslot_in    = eslot_ff;
      nak_in      = nak_ff;
      cnt_in      = cnt_ff;
      type_in     = type_ff;
      seq_in      = seq_ff;
      slot_in     = slot_ff;
      byte_in     = byte_ff;
      more_in     = more_ff;
      slot_ctl    = '0;
      emit        = 1'b0;
      emit_kind   = srr_pkg::KIND_ACK;
      emit_byte   = 8'd0;
      finish_move = 1'b0;

      case (state_ff)
         srr_pkg::ST_IDLE: begin
            if (accept) begin
               type_in  = req_type;
               seq_in   = seq_wide[SW-1:0];
               slot_in  = slot_wide[IW-1:0];
               byte_in  = req_frame_byte;
               more_in  = req_more_waiting;
               state_in = srr_pkg::ST_DECIDE;
            end
         end
         srr_pkg::ST_DECIDE: begin
            case (type_ff)
               srr_pkg::REQ_DATA: begin
                  if ((seq_ff != exp_ff) && nak_ff) begin
                     if (can_emit) begin
                        emit      = 1'b1;
                        emit_kind = srr_pkg::KIND_NAK;
                        nak_in    = 1'b0;
                        state_in  = srr_pkg::ST_FINISH;
                     end
                  end else if (in_win && !chk_filled) begin
                     slot_ctl.set = 1'b1;
                     cnt_in       = '0;
                     state_in     = srr_pkg::ST_DRAIN_RD;
                  end else begin
                     state_in = srr_pkg::ST_ACK;
                  end
               end
               srr_pkg::REQ_CRC_ERR: begin
                  if (!nak_ff) begin
                     state_in = srr_pkg::ST_FINISH;
                  end else if (can_emit) begin
                     emit      = 1'b1;
                     emit_kind = srr_pkg::KIND_NAK;
                     nak_in    = 1'b0;
                     state_in  = srr_pkg::ST_FINISH;
                  end
               end
               srr_pkg::REQ_TIMEOUT: begin
                  if (can_emit) begin
                     emit      = 1'b1;
                     emit_kind = srr_pkg::KIND_ACK;
                     state_in  = srr_pkg::ST_FINISH;
                  end
               end
               default: begin
                  state_in = srr_pkg::ST_FINISH;
               end
            endcase
         end
         srr_pkg::ST_DRAIN_RD: begin
            if ((cnt_ff == CW'(WINDOW)) || !chk_filled) begin
               state_in = srr_pkg::ST_ACK;
            end else begin
               slot_ctl.read = 1'b1;
               state_in      = srr_pkg::ST_DRAIN_EM;
            end
         end
         srr_pkg::ST_DRAIN_EM: begin
            if (can_emit) begin
               emit           = 1'b1;
               emit_kind      = srr_pkg::KIND_BYTE;
               emit_byte      = rd_byte;
               slot_ctl.clear = 1'b1;
               nak_in         = 1'b1;
               exp_in         = exp_wrap ? '0 : exp_ff + SW'(1);
               wup_in         = (wup_ff == SW'(SEQ_MAX)) ? '0 : wup_ff + SW'(1);
               // The slot pointer restarts with the sequence space or after the last slot.
               if (exp_wrap || (eslot_ff == IW'(WINDOW - 1))) begin
                  eslot_in = '0;
               end else begin
                  eslot_in = eslot_ff + IW'(1);
               end
               cnt_in   = cnt_ff + CW'(1);
               state_in = srr_pkg::ST_DRAIN_RD;
            end
         end
         srr_pkg::ST_ACK: begin
            if (more_ff) begin
               state_in = srr_pkg::ST_FINISH;
            end else if (can_emit) begin
               emit      = 1'b1;
               emit_kind = srr_pkg::KIND_ACK;
               state_in  = srr_pkg::ST_FINISH;
            end
         end
         srr_pkg::ST_FINISH: begin
            // The staged result, if any, is the last one of this request.
            if (!pend_valid_ff) begin
               state_in = srr_pkg::ST_IDLE;
            end else if (rsp_free) begin
               finish_move = 1'b1;
               state_in    = srr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srr_pkg::ST_IDLE;
         end
      endcase
   end

   // Staging and output registers. A new result pushes the staged one out
   // with rsp_last low; the end of the request pushes it out with rsp_last high.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_byte_in  = pend_byte_ff;
      pend_num_in   = pend_num_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_last_in   = rsp_last_ff;

      if ((emit && pend_valid_ff) || finish_move) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_kind_ff;
         rsp_byte_in  = pend_byte_ff;
         rsp_num_in   = pend_num_ff;
         rsp_last_in  = finish_move;
      end
      if (finish_move) begin
         pend_valid_in = 1'b0;
      end
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_kind_in  = emit_kind;
         pend_byte_in  = emit_byte;
         pend_num_in   = (emit_kind == srr_pkg::KIND_BYTE) ? 3'd0 : exp_num;
      end
   end

   srr_slot_buf #(
      .WINDOW (WINDOW)
   ) u_slot_buf (
      .clock      (clock),
      .reset      (reset),
      .ctl        (slot_ctl),
      .wr_idx     (slot_ff),
      .wr_byte    (byte_ff),
      .rd_idx     (eslot_ff),
      .rd_byte    (rd_byte),
      .chk_idx    (chk_idx),
      .chk_filled (chk_filled)
   );

   assign req_stall      = (state_ff != srr_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = rsp_kind_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_ack_number = rsp_num_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: hw/rtl/srr_checker.sv
// Port-level checker for the selective-repeat receiver.
// Sees only the top level's ports; bound to selective_repeat_receiver below.
module srr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_ack_number,
   input logic       rsp_last
);

   // A stalled response beat holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_kind) &&
         $stable(rsp_out_byte) && $stable(rsp_ack_number) && $stable(rsp_last)))
      else $error("stalled response beat changed");

   // One request at a time: the cycle after a request beat the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in work");

   // A response never carries an unused kind code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind == srr_pkg::KIND_BYTE ||
                     rsp_out_kind == srr_pkg::KIND_ACK ||
                     rsp_out_kind == srr_pkg::KIND_NAK))
      else $error("response carries unknown kind");

   // Delivered bytes carry no number, and ACK or NAK frames carry no byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_kind == srr_pkg::KIND_BYTE) ?
                     (rsp_ack_number == 3'd0) : (rsp_out_byte == 8'd0)))
      else $error("response fields inconsistent with kind");

   // The block is never ready for a new request while an unfinished one
   // still owes its final beat: a non-final beat is shown only while req_stall is high.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("ready while a request still owes response beats");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_kind   (rsp_out_kind),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_ack_number (rsp_ack_number),
   .rsp_last       (rsp_last)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Testbench for selective_repeat_receiver: frame, checksum-error, timeout and ignored-code
// beats go in, and every reply beat is checked against an in-bench receiver predictor.
// Depends on srr_pkg and the RTL of the block.
module testbench;

   // The package names no code for the ignored request type.
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int WIN = srr_pkg::WINDOW_DEF;
   localparam int RANDOM_FRAMES = 250;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] seq;
      logic [7:0] data;
      logic       more;
   } frame_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [2:0] number;
      logic       last;
   } reply_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = srr_pkg::REQ_DATA;
   logic [2:0] req_frame_seq = 3'd0;
   logic [7:0] req_frame_byte = 8'd0;
   logic       req_more_waiting = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_ack_number;
   logic       rsp_last;

   selective_repeat_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_frame_seq    (req_frame_seq),
      .req_frame_byte   (req_frame_byte),
      .req_more_waiting (req_more_waiting),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_ack_number   (rsp_ack_number),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   frame_type pending_frames [$];
   reply_type due_replies [$];
   int        live_frames = 0;
   int        fail_count = 0;
   logic      frame_taken = 1'b0;

   // Receiver state as the predictor sees it. Sequence numbers are three bits wide,
   // so plain vector arithmetic gives the wrap modulo eight.
   logic [2:0]     rx_expected = 3'd0;
   logic [2:0]     rx_edge = 3'(WIN);
   logic [WIN-1:0] slot_full = '0;
   logic [7:0]     slot_data [WIN];
   logic           nak_live = 1'b1;

   function automatic reply_type reply(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [2:0] number);
      return reply_type'{kind, data, number, 1'b0};
   endfunction

   // Works out the reply beats one request beat causes and queues them in order.
   function automatic void receive_frame(input frame_type f);
      reply_type  batch [$];
      logic [2:0] off;
      logic [2:0] span;
      int         slot;
      int         drained;
      case (f.kind)
         srr_pkg::REQ_DATA: begin
            if (f.seq != rx_expected && nak_live) begin
               // An out-of-order frame only draws a NAK while one is allowed.
               batch.push_back(reply(srr_pkg::KIND_NAK, 8'd0, rx_expected));
               nak_live = 1'b0;
            end else begin
               // Circular window test: distance from the expected number must be
               // smaller than the distance to the upper edge.
               off = f.seq - rx_expected;
               span = rx_edge - rx_expected;
               slot = f.seq % WIN;
               if (off < span && !slot_full[slot]) begin
                  slot_full[slot] = 1'b1;
                  slot_data[slot] = f.data;
                  drained = 0;
                  while (drained < WIN && slot_full[rx_expected % WIN]) begin
                     batch.push_back(reply(srr_pkg::KIND_BYTE,
                                           slot_data[rx_expected % WIN], 3'd0));
                     slot_full[rx_expected % WIN] = 1'b0;
                     rx_expected = rx_expected + 3'd1;
                     rx_edge = rx_edge + 3'd1;
                     nak_live = 1'b1;
                     drained++;
                  end
               end
               if (!f.more)
                  batch.push_back(reply(srr_pkg::KIND_ACK, 8'd0, rx_expected));
            end
         end
         srr_pkg::REQ_CRC_ERR: begin
            if (nak_live) begin
               batch.push_back(reply(srr_pkg::KIND_NAK, 8'd0, rx_expected));
               nak_live = 1'b0;
            end
         end
         srr_pkg::REQ_TIMEOUT: begin
            batch.push_back(reply(srr_pkg::KIND_ACK, 8'd0, rx_expected));
         end
         default: ;
      endcase
      if (batch.size() != 0)
         batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i])
         due_replies.push_back(batch[i]);
   endfunction

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: reply %s expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Mostly short idles, now and then a long one.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return $urandom_range(1, 2);
      else if (roll < 95)
         return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   task automatic push_frame(input logic [1:0] kind, input logic [2:0] seq,
                             input logic [7:0] data, input logic more);
      pending_frames.push_back(frame_type'{kind, seq, data, more});
      if (kind != REQ_UNKNOWN)
         live_frames++;
   endtask

   // A run of frames in sender order starting at the expected number.
   task automatic queue_in_order();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
         push_frame(srr_pkg::REQ_DATA, rx_expected + 3'(i), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
   endtask

   // One window's worth of frames in shuffled order, with the odd loss, repeat or
   // frame from outside the window. NAKs are disarmed first so that early frames
   // get buffered instead of being answered.
   task automatic queue_reordered();
      logic [2:0] offs [$];
      logic [2:0] base;
      logic [2:0] tmp;
      int         j;
      base = rx_expected;
      if (nak_live) begin
         if ($urandom_range(0, 1) == 0)
            push_frame(srr_pkg::REQ_CRC_ERR, 3'($urandom), 8'($urandom), 1'($urandom));
         else
            push_frame(srr_pkg::REQ_DATA, base + 3'($urandom_range(1, 7)), 8'($urandom),
                       1'($urandom));
      end
      for (int i = 0; i < WIN; i++)
         if ($urandom_range(0, 9) != 0)
            offs.push_back(3'(i));
      if ($urandom_range(0, 2) == 0)
         offs.push_back(3'($urandom_range(0, 7)));
      for (int i = offs.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = offs[i];
         offs[i] = offs[j];
         offs[j] = tmp;
      end
      foreach (offs[i])
         push_frame(srr_pkg::REQ_DATA, base + offs[i], 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
   endtask

   task automatic queue_link_events();
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
         push_frame($urandom_range(0, 1) ? srr_pkg::REQ_CRC_ERR : srr_pkg::REQ_TIMEOUT,
                    3'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic queue_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         push_frame(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // Request side: a beat is taken at the rising edge, and the predictor runs on it
   // right there so that expectations stay in acceptance order.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         receive_frame(pending_frames[0]);
         void'(pending_frames.pop_front());
         frame_taken = 1'b1;
      end
   end

   int   req_gap = 0;
   logic req_calm = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !frame_taken) begin
         // Stalled: the beat stays on the wires unchanged.
      end else begin
         frame_taken = 1'b0;
         if ($urandom_range(0, 63) == 0)
            req_calm = !req_calm;
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_frames.size() != 0) begin
            req_type <= pending_frames[0].kind;
            req_frame_seq <= pending_frames[0].seq;
            req_frame_byte <= pending_frames[0].data;
            req_more_waiting <= pending_frames[0].more;
            req_valid <= 1'b1;
            req_gap = (req_calm || $urandom_range(0, 1) == 0) ? 0 : idle_cycles();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Reply side back-pressure, with quiet stretches in between.
   int   stall_left = 0;
   logic rsp_calm = 1'b0;

   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0)
         rsp_calm = !rsp_calm;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_calm && $urandom_range(0, 3) == 0)
            stall_left = idle_cycles();
      end
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_replies.size() == 0) begin
            $display("%0t: unexpected reply beat kind %0d byte %0h number %0d last %0d",
                     $time, rsp_out_kind, rsp_out_byte, rsp_ack_number, rsp_last);
            fail_count++;
         end else begin
            want = due_replies.pop_front();
            compare_field("kind", 8'(want.kind), 8'(rsp_out_kind));
            compare_field("byte", want.data, rsp_out_byte);
            compare_field("ack number", 8'(want.number), 8'(rsp_ack_number));
            compare_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   initial begin
      int roll;
      int random_start;
      // Directed opening: in-order delivery with and without a trailing ACK.
      push_frame(srr_pkg::REQ_DATA, 3'd0, 8'h00, 1'b0);
      push_frame(srr_pkg::REQ_DATA, 3'd1, 8'hFF, 1'b1);
      // Wrong number while armed, then a checksum error with NAKs disarmed.
      push_frame(srr_pkg::REQ_DATA, 3'd5, 8'h00, 1'b0);
      push_frame(srr_pkg::REQ_CRC_ERR, 3'd0, 8'h00, 1'b0);
      // Buffered out-of-order frame, a duplicate of it and a frame past the window.
      push_frame(srr_pkg::REQ_DATA, 3'd3, 8'hA5, 1'b0);
      push_frame(srr_pkg::REQ_DATA, 3'd3, 8'h11, 1'b0);
      push_frame(srr_pkg::REQ_DATA, 3'd7, 8'h22, 1'b0);
      // Fill the window so the missing frame releases a full four-byte drain.
      push_frame(srr_pkg::REQ_DATA, 3'd5, 8'h5A, 1'b1);
      push_frame(srr_pkg::REQ_DATA, 3'd4, 8'h3C, 1'b1);
      push_frame(srr_pkg::REQ_DATA, 3'd2, 8'h81, 1'b0);
      push_frame(srr_pkg::REQ_TIMEOUT, 3'd0, 8'h00, 1'b0);
      push_frame(srr_pkg::REQ_CRC_ERR, 3'd0, 8'h00, 1'b0);
      push_frame(srr_pkg::REQ_CRC_ERR, 3'd0, 8'h00, 1'b0);
      push_frame(REQ_UNKNOWN, 3'd7, 8'hFF, 1'b1);
      push_frame(srr_pkg::REQ_DATA, 3'd6, 8'h7E, 1'b0);
      // Window that wraps past sequence number seven.
      push_frame(srr_pkg::REQ_CRC_ERR, 3'd0, 8'h00, 1'b0);
      push_frame(srr_pkg::REQ_DATA, 3'd1, 8'hC3, 1'b1);
      push_frame(srr_pkg::REQ_DATA, 3'd0, 8'h0F, 1'b1);
      push_frame(srr_pkg::REQ_DATA, 3'd7, 8'hF0, 1'b0);
      push_frame(srr_pkg::REQ_DATA, 3'd4, 8'h80, 1'b0);
      push_frame(srr_pkg::REQ_DATA, 3'd2, 8'h01, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Each random episode is built from the predictor state once the previous
      // one has been taken in whole.
      random_start = live_frames;
      while (live_frames - random_start < RANDOM_FRAMES) begin
         do @(negedge clock); while (pending_frames.size() != 0);
         @(posedge clock);
         roll = $urandom_range(0, 99);
         if (roll < 35)
            queue_in_order();
         else if (roll < 65)
            queue_reordered();
         else if (roll < 80)
            queue_link_events();
         else
            queue_noise();
      end

      while (pending_frames.size() != 0 || due_replies.size() != 0)
         @(negedge clock);
      // Room for a stray beat after the last expected one.
      repeat (30) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
